/* rtl/chained_hash_table_unit_defines.svh */
// Assertion macros used by the checker file of the hash table unit
`ifndef CHAINED_HASH_TABLE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, idle during reset
`define CHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define CHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cht_pkg.sv */
// Package of constants, codes and control types for the hash table unit
package cht_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int POOL_NODES  = 256;
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int LINK_W  = NODE_W + 1;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 64;
  localparam int CFG_W   = 7;
  localparam int KCNT_W  = $clog2(KEY_W);
  localparam int IN_W    = 104;
  localparam int OUT_W   = 72;

  localparam logic [LINK_W-1:0] NULL_NODE = LINK_W'(POOL_NODES);
  localparam logic [CFG_W-1:0]  BKT_RESET = CFG_W'(NUM_BUCKETS);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MOD   = 10'b0000000010,
    S_HEAD  = 10'b0000000100,
    S_HWAIT = 10'b0000001000,
    S_NODE  = 10'b0000010000,
    S_NWAIT = 10'b0000100000,
    S_INSN  = 10'b0001000000,
    S_INSL  = 10'b0010000000,
    S_DEL   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic    load;
    logic    mod_step;
    logic    head_rd;
    logic    head_cap;
    logic    node_rd;
    logic    node_adv;
    logic    ins_wr_node;
    logic    ins_wr_link;
    logic    del_wr;
    logic    res_load;
    status_t res_code;
    logic    res_hit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    pool_empty;
    logic    mod_last;
    logic    at_end;
    logic    key_gt;
    logic    key_eq;
    logic    out_busy;
  } stat_t;

endpackage

/* rtl/cht_ram.sv */
// Generic single-write, single-read RAM with registered read data
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/cht_ctrl.sv */
// Controller state machine sequencing one table operation at a time
module cht_ctrl import cht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) begin
          if (st.act == ACT_NONE) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_NOTFOUND;
            state_next   = S_DONE;
          end else if (st.act == ACT_INSERT && st.pool_empty) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_FULL;
            state_next   = S_DONE;
          end else begin
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_HWAIT;
      end
      S_HWAIT: begin
        cmd.head_cap = 1'b1;
        state_next   = S_NODE;
      end
      S_NODE: begin
        if (st.at_end) begin
          if (st.act == ACT_INSERT) begin
            state_next = S_INSN;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_NOTFOUND;
            state_next   = S_DONE;
          end
        end else begin
          cmd.node_rd = 1'b1;
          state_next  = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (st.act == ACT_INSERT) begin
          if (st.key_gt) begin
            cmd.node_adv = 1'b1;
            state_next   = S_NODE;
          end else begin
            state_next = S_INSN;
          end
        end else if (st.key_eq) begin
          if (st.act == ACT_DELETE) begin
            state_next = S_DEL;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_hit  = 1'b1;
            state_next   = S_DONE;
          end
        end else if (st.key_gt) begin
          cmd.node_adv = 1'b1;
          state_next   = S_NODE;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOTFOUND;
          state_next   = S_DONE;
        end
      end
      S_INSN: begin
        cmd.ins_wr_node = 1'b1;
        state_next      = S_INSL;
      end
      S_INSL: begin
        cmd.ins_wr_link = 1'b1;
        cmd.res_load    = 1'b1;
        state_next      = S_DONE;
      end
      S_DEL: begin
        cmd.del_wr   = 1'b1;
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/cht_dpath.sv */
// Datapath: modulo unit, bucket heads, node pool, free stack and result registers
module cht_dpath import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  cmd_t             cmd,
  output stat_t            st
);

  logic [CFG_W-1:0]  bucket_count;
  logic [CFG_W-1:0]  divisor;
  action_t           act;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [CFG_W-1:0]  rem;
  logic [CFG_W-1:0]  rem_shift;
  logic [KCNT_W-1:0] kcnt;
  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] prev;
  logic [LINK_W-1:0] steps;
  logic [NODE_W-1:0] new_node;
  logic [LINK_W-1:0] free_count;
  logic [NUM_BUCKETS-1:0] head_vld;
  logic [LINK_W-1:0] fs_low;
  logic              head_vld_q;
  logic              fs_vld_q;
  logic [NODE_W-1:0] fs_idx_q;
  status_t           res_status;
  logic [VAL_W-1:0]  res_found;

  logic [BKT_W-1:0]  bucket;
  logic [LINK_W-1:0] head_rdata;
  logic [NODE_W-1:0] fs_rdata;
  logic [KEY_W-1:0]  nkey_rdata;
  logic [VAL_W-1:0]  nval_rdata;
  logic [LINK_W-1:0] nlink_rdata;
  logic [NODE_W-1:0] fs_pop_idx;
  logic [LINK_W-1:0] fs_pop_ext;
  logic              prev_null;
  logic              head_we;
  logic [LINK_W-1:0] head_wdata;
  logic              link_we;
  logic [NODE_W-1:0] link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              fs_push;

  always_comb begin
    if (bucket_count == '0) begin
      divisor = CFG_W'(1);
    end else if (bucket_count > BKT_RESET) begin
      divisor = BKT_RESET;
    end else begin
      divisor = bucket_count;
    end
  end

  assign rem_shift  = {rem[CFG_W-2:0], key[kcnt]};
  assign bucket     = rem[BKT_W-1:0];
  assign fs_pop_ext = free_count - LINK_W'(1);
  assign fs_pop_idx = fs_pop_ext[NODE_W-1:0];
  assign prev_null  = prev[NODE_W];
  assign fs_push    = cmd.del_wr && (free_count < LINK_W'(POOL_NODES));

  assign head_we    = (cmd.ins_wr_link || cmd.del_wr) && prev_null;
  assign head_wdata = cmd.del_wr ? nlink_rdata : {1'b0, new_node};
  assign link_we    = cmd.ins_wr_node || ((cmd.ins_wr_link || cmd.del_wr) && !prev_null);
  assign link_waddr = cmd.ins_wr_node ? new_node : prev[NODE_W-1:0];
  always_comb begin
    if (cmd.ins_wr_node) begin
      link_wdata = cur;
    end else if (cmd.del_wr) begin
      link_wdata = nlink_rdata;
    end else begin
      link_wdata = {1'b0, new_node};
    end
  end

  cht_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(bucket), .wdata(head_wdata),
    .re(cmd.head_rd), .raddr(bucket), .rdata(head_rdata)
  );

  cht_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_keys (
    .clk(clk), .we(cmd.ins_wr_node), .waddr(new_node), .wdata(key),
    .re(cmd.node_rd), .raddr(cur[NODE_W-1:0]), .rdata(nkey_rdata)
  );

  cht_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_vals (
    .clk(clk), .we(cmd.ins_wr_node), .waddr(new_node), .wdata(value),
    .re(cmd.node_rd), .raddr(cur[NODE_W-1:0]), .rdata(nval_rdata)
  );

  cht_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(cmd.node_rd), .raddr(cur[NODE_W-1:0]), .rdata(nlink_rdata)
  );

  cht_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_free (
    .clk(clk), .we(fs_push), .waddr(free_count[NODE_W-1:0]), .wdata(cur[NODE_W-1:0]),
    .re(cmd.head_rd && act == ACT_INSERT), .raddr(fs_pop_idx), .rdata(fs_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BKT_RESET;
      head_vld     <= '0;
      fs_low       <= LINK_W'(POOL_NODES);
      free_count   <= LINK_W'(POOL_NODES);
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_wdata;
      end
      if (head_we) begin
        head_vld[bucket] <= 1'b1;
      end
      if (fs_push) begin
        free_count <= free_count + LINK_W'(1);
      end else if (cmd.head_rd && act == ACT_INSERT) begin
        free_count <= free_count - LINK_W'(1);
        if (fs_pop_ext < fs_low) begin
          fs_low <= fs_pop_ext;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= action_t'(s_tdata[1:0]);
      key   <= s_tdata[KEY_W+1:2];
      value <= s_tdata[VAL_W+KEY_W+1:KEY_W+2];
      rem   <= '0;
      kcnt  <= KCNT_W'(KEY_W - 1);
    end
    if (cmd.mod_step) begin
      rem  <= (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
      kcnt <= kcnt - KCNT_W'(1);
    end
    if (cmd.head_rd) begin
      head_vld_q <= head_vld[bucket];
      fs_vld_q   <= (fs_pop_ext >= fs_low);
      fs_idx_q   <= fs_pop_idx;
    end
    if (cmd.head_cap) begin
      cur      <= head_vld_q ? head_rdata : NULL_NODE;
      prev     <= NULL_NODE;
      steps    <= '0;
      new_node <= fs_vld_q ? fs_rdata : fs_idx_q;
    end
    if (cmd.node_adv) begin
      prev  <= cur;
      cur   <= nlink_rdata;
      steps <= steps + LINK_W'(1);
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_found  <= cmd.res_hit ? nval_rdata : '0;
    end
    if (cmd.out_load) begin
      m_tdata <= {{(OUT_W - VAL_W - 2){1'b0}}, res_found, res_status};
    end
  end

  assign st.act        = act;
  assign st.pool_empty = (free_count == '0);
  assign st.mod_last   = (kcnt == '0);
  assign st.at_end     = cur[NODE_W] || (steps == LINK_W'(POOL_NODES));
  assign st.key_gt     = key > nkey_rdata;
  assign st.key_eq     = key == nkey_rdata;
  assign st.out_busy   = m_tvalid && !m_tready;

endmodule

/* rtl/chained_hash_table_unit.sv */
// Top level of the chained hash table unit
//
//  channel   dir  fields (low bit up)                         transfer when
//  s_axis    in   action[1:0] key[32:2] value[96:33]          s_tvalid && s_tready
//  m_axis    out  status[1:0] found_value[65:2]               m_tvalid && m_tready
//  cfg       in   bucket_count[6:0]                           cfg_we
//
//  One operation at a time: accept, bit-serial modulo of the key, bucket head
//  read, a walk along the chain node by node that may reach the chain end,
//  an insert link-up or a delete unlink, and the hand-over of the result.
//  Synchronous reset empties every bucket and refills the free stack at once.
//  A stalled result holds in the output register; the next item waits for it.
module chained_hash_table_unit import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,     // bucket_count
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,       // action, key, value, zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata        // status, found_value, zero fill
);

  cmd_t  cmd;
  stat_t st;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .st(st), .cmd(cmd)
  );

  cht_dpath u_dpath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .cmd(cmd), .st(st)
  );

endmodule

/* rtl/cht_checker.sv */
// Port-level checker for the hash table unit and its bind
`include "chained_hash_table_unit_defines.svh"

module cht_checker import cht_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `CHT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `CHT_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transfer taken early")
  `CHT_ASSERT_IMP(a_status_code, m_tvalid, (m_tdata[1:0] == ST_OK) || (m_tdata[1:0] == ST_NOTFOUND) || (m_tdata[1:0] == ST_FULL), "undefined status code")
  `CHT_ASSERT_IMP(a_miss_zero, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[65:2] == '0, "value shown on a miss")

endmodule

bind chained_hash_table_unit cht_checker u_cht_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* test/testbench.sv */
// Self-checking testbench for the chained hash table unit: table operations against a predictor
`timescale 1ns / 100ps

module testbench;
  import cht_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [63:0] found_value;
  } table_reply_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  chained_hash_table_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CFG_W-1:0]  divisor_reg;
  logic [LINK_W-1:0] heads[NUM_BUCKETS];
  logic [KEY_W-1:0]  pool_key[POOL_NODES];
  logic [VAL_W-1:0]  pool_val[POOL_NODES];
  logic [LINK_W-1:0] pool_link[POOL_NODES];
  logic [LINK_W-1:0] free_nodes[POOL_NODES];
  int                free_left;

  table_reply_t replies_due[$];
  int  errors = 0;
  int  replies_seen = 0;
  int  items_sent = 0;
  int  hold_off = 0;
  int  rx_wait = 0;
  logic [KEY_W-1:0] recent_keys[$];

  task automatic table_clear();
    divisor_reg = BKT_RESET;
    for (int i = 0; i < NUM_BUCKETS; i++) heads[i] = NULL_NODE;
    for (int i = 0; i < POOL_NODES; i++) free_nodes[i] = LINK_W'(i);
    free_left = POOL_NODES;
  endtask

  function automatic int bucket_of(logic [KEY_W-1:0] k);
    int d;
    d = divisor_reg;
    if (d == 0) d = 1;
    if (d > NUM_BUCKETS) d = NUM_BUCKETS;
    return k % d;
  endfunction

  function automatic table_reply_t table_apply(action_t act, logic [KEY_W-1:0] k,
                                               logic [VAL_W-1:0] v);
    table_reply_t r;
    int b, cur, prv, n, steps;
    r.status = ST_NOTFOUND;
    r.found_value = '0;
    b = bucket_of(k);
    cur = heads[b];
    prv = POOL_NODES;
    steps = 0;
    case (act)
      ACT_INSERT: begin
        if (free_left == 0) begin
          r.status = ST_FULL;
        end else begin
          free_left--;
          n = free_nodes[free_left];
          while (cur < POOL_NODES && steps < POOL_NODES && k > pool_key[cur]) begin
            prv = cur;
            cur = pool_link[cur];
            steps++;
          end
          pool_key[n] = k;
          pool_val[n] = v;
          pool_link[n] = (cur < POOL_NODES) ? LINK_W'(cur) : NULL_NODE;
          if (prv < POOL_NODES) pool_link[prv] = LINK_W'(n);
          else heads[b] = LINK_W'(n);
          r.status = ST_OK;
        end
      end
      ACT_DELETE, ACT_FIND: begin
        while (cur < POOL_NODES && steps < POOL_NODES && pool_key[cur] <= k) begin
          if (pool_key[cur] == k) begin
            r.status = ST_OK;
            if (act == ACT_FIND) begin
              r.found_value = pool_val[cur];
            end else begin
              if (prv < POOL_NODES) pool_link[prv] = pool_link[cur];
              else heads[b] = pool_link[cur];
              free_nodes[free_left] = LINK_W'(cur);
              free_left++;
            end
            break;
          end
          prv = cur;
          cur = pool_link[cur];
          steps++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_op(action_t act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                         bit gaps = 1);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 5) : 0;
    if ($urandom_range(0, 3) == 0) wait_cycles = 0;
    if (wait_cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= {(IN_W/4){4'hA}} ^ {IN_W{$urandom_range(0, 1) == 1}};
      repeat (wait_cycles) @(posedge clk);
    end
    replies_due.push_back(table_apply(act, k, v));
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, v, k, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (act == ACT_INSERT && k < 1000) recent_keys.push_back(k);
    if (recent_keys.size() > 64) void'(recent_keys.pop_front());
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_buckets(logic [CFG_W-1:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    divisor_reg = n;
  endtask

  // receiver: drawn wait per result, plus a long hold-off on request
  always @(posedge clk) begin
    int w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      w = $urandom_range(0, 5);
      rx_wait <= w;
      m_tready <= (w == 0);
    end else if (!m_tready) begin
      if (rx_wait == 0) m_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  always @(posedge clk) begin
    table_reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[1:0], m_tdata[65:2]};
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.found_value !== want.found_value) begin
          $display("%0t: found_value expected %h actual %h", $time,
                   want.found_value, got.found_value);
          errors++;
        end
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom);
      1: return (recent_keys.size() > 0) ?
                recent_keys[$urandom_range(0, recent_keys.size() - 1)] : '0;
      default: return KEY_W'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic test_directed();
    send_op(ACT_FIND, 31'd5, 64'd0);
    send_op(ACT_DELETE, 31'd5, 64'd0);
    send_op(ACT_INSERT, 31'd0, 64'd0);
    send_op(ACT_INSERT, 31'h7FFFFFFF, 64'hFFFFFFFFFFFFFFFF);
    send_op(ACT_INSERT, 31'd64, 64'h1111);
    send_op(ACT_INSERT, 31'd64, 64'h2222);
    send_op(ACT_INSERT, 31'd128, 64'h3333);
    send_op(ACT_FIND, 31'd64, 64'hFFFF);
    send_op(ACT_FIND, 31'd1, 64'd0);
    send_op(ACT_FIND, 31'h7FFFFFFF, 64'd0);
    send_op(ACT_FIND, 31'd0, 64'd0);
    send_op(ACT_DELETE, 31'd64, 64'd0);
    send_op(ACT_FIND, 31'd64, 64'd0);
    send_op(ACT_DELETE, 31'd100, 64'd0);
    send_op(ACT_NONE, 31'd64, 64'h5A5A);
    send_op(ACT_FIND, 31'd128, 64'd0);
  endtask

  task automatic test_bucket_counts();
    write_buckets(7'd0);
    send_op(ACT_FIND, 31'd128, 64'd0);
    send_op(ACT_INSERT, 31'd3, 64'hABCD);
    send_op(ACT_FIND, 31'd3, 64'd0);
    write_buckets(7'd127);
    send_op(ACT_FIND, 31'd3, 64'd0);
    send_op(ACT_FIND, 31'd64, 64'd0);
    write_buckets(7'd1);
    send_op(ACT_FIND, 31'h7FFFFFFF, 64'd0);
    write_buckets(7'd64);
  endtask

  task automatic test_pool_full();
    for (int i = 0; i < POOL_NODES + 4; i++)
      send_op(ACT_INSERT, KEY_W'($urandom_range(0, 500)), {$urandom, $urandom}, 0);
    send_op(ACT_FIND, 31'd7, 64'd0);
    for (int i = 0; i < POOL_NODES + 4; i++)
      send_op(ACT_DELETE, KEY_W'($urandom_range(0, 500)), 64'd0, i % 3 == 0);
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 300;
    for (int i = 0; i < 12; i++)
      send_op(action_t'($urandom_range(0, 2)), pick_key(), {$urandom, $urandom}, 0);
  endtask

  task automatic test_random(int count, logic [CFG_W-1:0] n);
    int r;
    action_t act;
    write_buckets(n);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      act = (r < 45) ? ACT_INSERT : (r < 70) ? ACT_FIND : (r < 97) ? ACT_DELETE : ACT_NONE;
      if (free_left < 20 && act == ACT_INSERT) act = ACT_DELETE;
      send_op(act, pick_key(), {$urandom, $urandom});
    end
  endtask

  initial begin
    table_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_bucket_counts();
    test_pool_full();
    test_backpressure();
    test_random(300, 7'd64);
    test_random(250, 7'd1);
    test_random(250, 7'd13);
    test_random(250, 7'd127);
    write_buckets(7'd33);
    drain();
    $display("Ran %0d table operations, %0d results checked, across bucket counts 0 to 127",
             items_sent, replies_seen);
    $display("including pool exhaustion, duplicate keys and a long output stall");
    if (errors == 0 && replies_due.size() == 0) begin
      $display("chained_hash_table_unit test passed");
    end else begin
      $display("chained_hash_table_unit test failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("chained_hash_table_unit test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_ctrl.sv
rtl/cht_dpath.sv
rtl/chained_hash_table_unit.sv
rtl/cht_checker.sv
test/testbench.sv
